### rtl/core/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication, disabled in reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Clocked next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/hprt_pkg.sv
`timescale 1ns / 1ps
package hprt_pkg;
    localparam int HAZARD_SLOTS  = 16;
    localparam int RETIRED_DEPTH = 32;
    localparam int POINTER_BITS  = 48;
    localparam int SLOT_W = $clog2(HAZARD_SLOTS);
    localparam int RET_W  = $clog2(RETIRED_DEPTH);
    localparam int CNT_W  = $clog2(RETIRED_DEPTH + 1);

    localparam logic [2:0] OP_ACQUIRE = 3'd0;
    localparam logic [2:0] OP_RELEASE = 3'd1;
    localparam logic [2:0] OP_PROTECT = 3'd2;
    localparam logic [2:0] OP_RETIRE  = 3'd3;
    localparam logic [2:0] OP_SCAN    = 3'd4;

    localparam logic [1:0] KIND_GRANTED   = 2'd0;
    localparam logic [1:0] KIND_NONE_FREE = 2'd1;
    localparam logic [1:0] KIND_DONE      = 2'd2;
    localparam logic [1:0] KIND_FREED     = 2'd3;

    typedef logic [POINTER_BITS-1:0] ptr_t;
endpackage

### rtl/core/hprt_ram.sv
`timescale 1ns / 1ps
module hprt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/core/hazard_pointer_reclaim_table.sv
`timescale 1ns / 1ps
// Sequence: acquire/release/protect/null retire/unknown go through EXEC, then DONE;
//   a retire into a list with room goes EXEC, POST, DONE. Scan: EXEC, then RD and CHK
//   per word (one RAM read, then slot match), a final RD, then DONE; full retire adds POST.
// Throughput: busy until the done word; one op at a time. The receiver cannot stall.
// Reset (rst_n low, async): slots inactive and cleared, retired count zero;
//   retired-list RAM is not cleared (only entries below the count are read).
module hazard_pointer_reclaim_table
    import hprt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  opcode,
    input  logic [3:0]  slot_index,
    input  logic [47:0] pointer_value,
    output logic        strobe,
    output logic [1:0]  result_kind,
    output logic [3:0]  granted_slot,
    output logic [47:0] freed_pointer,
    output logic        last
);
`include "assert_macros.svh"

    // Sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;  // slot op / decide
    localparam logic [2:0] ST_RD   = 3'd2;  // issue list read
    localparam logic [2:0] ST_CHK  = 3'd3;  // match read word against slots
    localparam logic [2:0] ST_POST = 3'd4;  // retire: append to list, or emit the pointer if still full after scan
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [2:0]  op_reg;
    logic [3:0]  slot_reg;
    ptr_t        ptr_reg;
    logic        scan_for_retire_reg, scan_for_retire_next;

    // Hazard slots: 16 entries, each compared at a fixed place, kept in flops.
    logic [HAZARD_SLOTS-1:0] active_reg;
    ptr_t                    sptr_reg [HAZARD_SLOTS];

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] rd_reg, rd_next;   // scan read index
    logic [CNT_W-1:0] wr_reg, wr_next;   // scan compaction index

    // Retired-list RAM
    logic            ram_we;
    logic [RET_W-1:0] ram_waddr, ram_raddr;
    ptr_t            ram_wdata, ram_rdata;

    hprt_ram #(.WIDTH(POINTER_BITS), .DEPTH(RETIRED_DEPTH)) u_list (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output word registers
    logic        strobe_next;
    logic [1:0]  kind_next;
    logic [3:0]  gslot_next;
    ptr_t        fptr_next;
    logic        last_next;

    // Lowest free slot
    logic [SLOT_W-1:0] free_idx;
    logic              free_any;
    always_comb
    begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = HAZARD_SLOTS - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_idx = SLOT_W'(i);
                free_any = 1'b1;
            end
        end
    end

    // Is the RAM word held by an active slot
    logic held;
    always_comb
    begin
        held = 1'b0;
        for (int i = 0; i < HAZARD_SLOTS; i++)
        begin
            if (active_reg[i] && sptr_reg[i] == ram_rdata)
            begin
                held = 1'b1;
            end
        end
    end

    logic slot_ok;
    assign slot_ok = ({1'b0, slot_reg} < 5'(HAZARD_SLOTS));

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next           = state_reg;
        scan_for_retire_next = scan_for_retire_reg;
        count_next           = count_reg;
        rd_next              = rd_reg;
        wr_next              = wr_reg;
        ram_we               = 1'b0;
        ram_waddr            = wr_reg[RET_W-1:0];
        ram_wdata            = ram_rdata;
        ram_raddr            = rd_reg[RET_W-1:0];
        strobe_next          = 1'b0;
        kind_next            = KIND_DONE;
        gslot_next           = '0;
        fptr_next            = '0;
        last_next            = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_DONE;
                rd_next    = '0;
                wr_next    = '0;
                scan_for_retire_next = 1'b0;
                case (op_reg)
                    OP_ACQUIRE:
                    begin
                        strobe_next = 1'b1;
                        if (free_any)
                        begin
                            kind_next  = KIND_GRANTED;
                            gslot_next = 4'(free_idx);
                        end
                        else
                        begin
                            kind_next = KIND_NONE_FREE;
                        end
                    end
                    OP_RETIRE:
                    begin
                        if (ptr_reg != '0)
                        begin
                            if (count_reg >= CNT_W'(RETIRED_DEPTH))
                            begin
                                scan_for_retire_next = 1'b1;
                                state_next = ST_RD;
                            end
                            else
                            begin
                                state_next = ST_POST;
                            end
                        end
                    end
                    OP_SCAN:
                    begin
                        state_next = ST_RD;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_RD:
            begin
                if (rd_reg >= count_reg)
                begin
                    count_next = wr_reg;
                    state_next = scan_for_retire_reg ? ST_POST : ST_DONE;
                end
                else
                begin
                    state_next = ST_CHK;
                end
            end
            ST_CHK:
            begin
                if (held)
                begin
                    ram_we  = 1'b1;
                    wr_next = wr_reg + CNT_W'(1);
                end
                else
                begin
                    strobe_next = 1'b1;
                    kind_next   = KIND_FREED;
                    fptr_next   = ram_rdata;
                end
                rd_next    = rd_reg + CNT_W'(1);
                ram_raddr  = rd_next[RET_W-1:0];
                state_next = ST_RD;
            end
            ST_POST:
            begin
                if (count_reg >= CNT_W'(RETIRED_DEPTH))
                begin
                    strobe_next = 1'b1;
                    kind_next   = KIND_FREED;
                    fptr_next   = ptr_reg;
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = count_reg[RET_W-1:0];
                    ram_wdata  = ptr_reg;
                    count_next = count_reg + CNT_W'(1);
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                strobe_next = 1'b1;
                kind_next   = KIND_DONE;
                last_next   = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            scan_for_retire_reg <= 1'b0;
            count_reg           <= '0;
            rd_reg              <= '0;
            wr_reg              <= '0;
            strobe              <= 1'b0;
            active_reg          <= '0;
        end
        else
        begin
            state_reg           <= state_next;
            scan_for_retire_reg <= scan_for_retire_next;
            count_reg           <= count_next;
            rd_reg              <= rd_next;
            wr_reg              <= wr_next;
            strobe              <= strobe_next;
            if (state_reg == ST_EXEC)
            begin
                if (op_reg == OP_ACQUIRE && free_any)
                begin
                    active_reg[free_idx] <= 1'b1;
                end
                else if (op_reg == OP_RELEASE && slot_ok)
                begin
                    active_reg[slot_reg[SLOT_W-1:0]] <= 1'b0;
                end
            end
        end
    end

    // Slot pointers: reset to zero, only meaningful while active but cleared anyway.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HAZARD_SLOTS; i++)
            begin
                sptr_reg[i] <= '0;
            end
        end
        else if (state_reg == ST_EXEC)
        begin
            if (op_reg == OP_ACQUIRE && free_any)
            begin
                sptr_reg[free_idx] <= '0;
            end
            else if (op_reg == OP_RELEASE && slot_ok)
            begin
                sptr_reg[slot_reg[SLOT_W-1:0]] <= '0;
            end
            else if (op_reg == OP_PROTECT && slot_ok && active_reg[slot_reg[SLOT_W-1:0]])
            begin
                sptr_reg[slot_reg[SLOT_W-1:0]] <= ptr_reg;
            end
        end
    end

    // Captured command word and result payload
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            op_reg   <= opcode;
            slot_reg <= slot_index;
            ptr_reg  <= pointer_value;
        end
        result_kind   <= kind_next;
        granted_slot  <= gslot_next;
        freed_pointer <= fptr_next;
        last          <= last_next;
    end

    `ASSERT_IMPL(a_count_range, 1'b1, count_reg <= CNT_W'(RETIRED_DEPTH), "retired count overflow")
    `ASSERT_IMPL(a_wr_le_rd, busy, wr_reg <= rd_reg, "compaction index passed read index")
    `ASSERT_NEXT(a_done_last, state_reg == ST_DONE, strobe && last, "done word missing")
    `ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted command did not go busy")
endmodule
